// ----- rtl/convex_polygon_overlap_sat_macros.svh -----
// Assertion macros for the polygon overlap block
`ifndef CONVEX_POLYGON_OVERLAP_SAT_MACROS_SVH
`define CONVEX_POLYGON_OVERLAP_SAT_MACROS_SVH
// property a implies b in the next cycle
`define CPO_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// property a implies b in the same cycle
`define CPO_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ----- rtl/cpo_pkg.sv -----
// Package: types and constants for the polygon overlap block
package cpo_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int NRM_W = COORD_BITS + 1;
    localparam int PRD_W = COORD_BITS + NRM_W;
    localparam int PRJ_W = PRD_W + 1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef struct packed {
        logic req_type;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic last_of_pair;
    } in_item_t;

    typedef struct packed {
        logic overlap;
        logic [1:0] status;
    } out_item_t;

    // job handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] cnt0;
        logic [CNT_W-1:0] cnt1;
        logic dropped;
    } job_t;

    // vertex write from front to back store
    typedef struct packed {
        logic en;
        logic poly;
        logic [IDX_W-1:0] idx;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } vwr_t;
endpackage

// ----- rtl/convex_polygon_overlap_sat.sv -----
// Operation: each vertex is stored and counted unless its polygon is full; the final vertex of a
// pair also starts a test in which one shared projection unit walks each tested edge against
// every vertex of both polygons.
// busy stays high from the final vertex until the result strobe; items then resume.
// Reset (async, active low) clears vertex counts, the drop flag and the sequencer.
module convex_polygon_overlap_sat (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cpo_pkg::in_item_t in_item,
    output logic result_valid,
    output cpo_pkg::out_item_t result
);
    logic take, job_valid, done;
    logic pend_reg;
    cpo_pkg::vwr_t vwr;
    cpo_pkg::job_t job;

    assign take = start && !busy;
    assign busy = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (job_valid)
            pend_reg <= 1'b1;
        else if (done)
            pend_reg <= 1'b0;
    end

    cpo_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .item(in_item),
        .vwr(vwr), .job_valid(job_valid), .job(job)
    );

    cpo_back u_back (
        .clk(clk), .rst_n(rst_n), .vwr(vwr), .job_valid(job_valid), .job(job),
        .done(done), .res(result)
    );

    assign result_valid = done;
endmodule

// ----- rtl/cpo_front.sv -----
// Front end: accepts vertices, counts them, issues test jobs
module cpo_front (
    input  logic clk,
    input  logic rst_n,
    input  logic take,
    input  cpo_pkg::in_item_t item,
    output cpo_pkg::vwr_t vwr,
    output logic job_valid,
    output cpo_pkg::job_t job
);
    logic [cpo_pkg::CNT_W-1:0] cnt0_reg, cnt1_reg, cnt0_next, cnt1_next;
    logic drop_reg, drop_next;
    logic full;

    always_comb
    begin
        full = item.req_type ? (cnt1_reg == cpo_pkg::CNT_W'(cpo_pkg::MAX_VERTICES))
                             : (cnt0_reg == cpo_pkg::CNT_W'(cpo_pkg::MAX_VERTICES));
        vwr.en = take && !full;
        vwr.poly = item.req_type;
        vwr.idx = item.req_type ? cnt1_reg[cpo_pkg::IDX_W-1:0]
                                : cnt0_reg[cpo_pkg::IDX_W-1:0];
        vwr.x = item.vertex_x[cpo_pkg::COORD_BITS-1:0];
        vwr.y = item.vertex_y[cpo_pkg::COORD_BITS-1:0];
        cnt0_next = cnt0_reg;
        cnt1_next = cnt1_reg;
        drop_next = drop_reg;
        if (take)
        begin
            if (full)
                drop_next = 1'b1;
            else if (item.req_type)
                cnt1_next = cnt1_reg + 1'b1;
            else
                cnt0_next = cnt0_reg + 1'b1;
        end
        job_valid = take && item.last_of_pair;
        job.cnt0 = cnt0_next;
        job.cnt1 = cnt1_next;
        job.dropped = drop_next;
        if (job_valid)
        begin
            cnt0_next = '0;
            cnt1_next = '0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt0_reg <= '0;
            cnt1_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            cnt0_reg <= cnt0_next;
            cnt1_reg <= cnt1_next;
            drop_reg <= drop_next;
        end
    end
endmodule

// ----- rtl/cpo_back.sv -----
// Back end: vertex stores and sequential separating-axis test
module cpo_back (
    input  logic clk,
    input  logic rst_n,
    input  cpo_pkg::vwr_t vwr,
    input  logic job_valid,
    input  cpo_pkg::job_t job,
    output logic done,
    output cpo_pkg::out_item_t res
);
    typedef enum logic [2:0] {S_IDLE, S_EDGE, S_PROJ, S_CMP, S_OUT} state_t;
    localparam int CW = cpo_pkg::COORD_BITS;

    logic signed [CW-1:0] px0 [cpo_pkg::MAX_VERTICES];
    logic signed [CW-1:0] py0 [cpo_pkg::MAX_VERTICES];
    logic signed [CW-1:0] px1 [cpo_pkg::MAX_VERTICES];
    logic signed [CW-1:0] py1 [cpo_pkg::MAX_VERTICES];

    state_t state_reg;
    cpo_pkg::job_t job_reg;
    logic epoly_reg;                       // polygon owning current edge
    logic [cpo_pkg::IDX_W-1:0] ei_reg;     // edge index
    logic ppoly_reg;                       // polygon being projected
    logic [cpo_pkg::IDX_W-1:0] pk_reg;
    logic first_reg;                       // first projection of a polygon
    logic ph_reg;                          // 0: read edge start, 1: edge end
    logic signed [CW-1:0] ax_reg, ay_reg;
    logic signed [cpo_pkg::NRM_W-1:0] nx_reg, ny_reg;
    logic signed [cpo_pkg::PRJ_W-1:0] lo0_reg, hi0_reg, lo1_reg, hi1_reg;
    logic signed [cpo_pkg::PRJ_W-1:0] proj;
    logic signed [CW-1:0] rx, ry, vx, vy;
    logic [cpo_pkg::IDX_W-1:0] ej;
    logic [cpo_pkg::CNT_W-1:0] ecnt, pcnt;
    logic done_reg;
    cpo_pkg::out_item_t res_reg;

    always_ff @(posedge clk)
    begin
        if (vwr.en)
        begin
            if (vwr.poly)
            begin
                px1[vwr.idx] <= vwr.x;
                py1[vwr.idx] <= vwr.y;
            end
            else
            begin
                px0[vwr.idx] <= vwr.x;
                py0[vwr.idx] <= vwr.y;
            end
        end
    end

    always_comb
    begin
        ecnt = epoly_reg ? job_reg.cnt1 : job_reg.cnt0;
        pcnt = ppoly_reg ? job_reg.cnt1 : job_reg.cnt0;
        ej = ({1'b0, ei_reg} + 1'b1 == ecnt) ? '0 : ei_reg + 1'b1;
        rx = epoly_reg ? px1[ph_reg ? ej : ei_reg] : px0[ph_reg ? ej : ei_reg];
        ry = epoly_reg ? py1[ph_reg ? ej : ei_reg] : py0[ph_reg ? ej : ei_reg];
        vx = ppoly_reg ? px1[pk_reg] : px0[pk_reg];
        vy = ppoly_reg ? py1[pk_reg] : py0[pk_reg];
        proj = cpo_pkg::PRJ_W'(vx * nx_reg) + cpo_pkg::PRJ_W'(vy * ny_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            ph_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        job_reg <= job;
                        epoly_reg <= 1'b0;
                        ei_reg <= '0;
                        ph_reg <= 1'b0;
                        if (job.cnt0 == '0 || job.cnt1 == '0)
                        begin
                            res_reg.overlap <= 1'b0;
                            res_reg.status <= cpo_pkg::STATUS_EMPTY;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_EDGE;
                    end
                S_EDGE:
                begin
                    if (!ph_reg)
                    begin
                        ax_reg <= rx;
                        ay_reg <= ry;
                        ph_reg <= 1'b1;
                    end
                    else
                    begin
                        nx_reg <= cpo_pkg::NRM_W'(ay_reg) - cpo_pkg::NRM_W'(ry);
                        ny_reg <= cpo_pkg::NRM_W'(rx) - cpo_pkg::NRM_W'(ax_reg);
                        ph_reg <= 1'b0;
                        ppoly_reg <= 1'b0;
                        pk_reg <= '0;
                        first_reg <= 1'b1;
                        state_reg <= S_PROJ;
                    end
                end
                S_PROJ:
                begin
                    first_reg <= 1'b0;
                    if (ppoly_reg)
                    begin
                        if (first_reg || proj < lo1_reg) lo1_reg <= proj;
                        if (first_reg || proj > hi1_reg) hi1_reg <= proj;
                    end
                    else
                    begin
                        if (first_reg || proj < lo0_reg) lo0_reg <= proj;
                        if (first_reg || proj > hi0_reg) hi0_reg <= proj;
                    end
                    if ({1'b0, pk_reg} + 1'b1 == pcnt)
                    begin
                        pk_reg <= '0;
                        first_reg <= 1'b1;
                        if (ppoly_reg)
                            state_reg <= S_CMP;
                        else
                            ppoly_reg <= 1'b1;
                    end
                    else
                        pk_reg <= pk_reg + 1'b1;
                end
                S_CMP:
                begin
                    if (lo1_reg > hi0_reg || lo0_reg > hi1_reg)
                    begin
                        res_reg.overlap <= 1'b0;
                        res_reg.status <= job_reg.dropped ? cpo_pkg::STATUS_DROPPED
                                                          : cpo_pkg::STATUS_OK;
                        state_reg <= S_OUT;
                    end
                    else if ({1'b0, ei_reg} + 1'b1 == ecnt)
                    begin
                        if (epoly_reg)
                        begin
                            res_reg.overlap <= 1'b1;
                            res_reg.status <= job_reg.dropped ? cpo_pkg::STATUS_DROPPED
                                                              : cpo_pkg::STATUS_OK;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            epoly_reg <= 1'b1;
                            ei_reg <= '0;
                            state_reg <= S_EDGE;
                        end
                    end
                    else
                    begin
                        ei_reg <= ei_reg + 1'b1;
                        state_reg <= S_EDGE;
                    end
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res = res_reg;
endmodule

// ----- rtl/cpo_checker.sv -----
// Port-level checker for the polygon overlap block, with bind
`include "convex_polygon_overlap_sat_macros.svh"
module cpo_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cpo_pkg::in_item_t in_item,
    input logic result_valid,
    input cpo_pkg::out_item_t result
);
    `CPO_ASSERT_NEXT(a_last_busy, clk, rst_n, start && !busy && in_item.last_of_pair, busy)
    `CPO_ASSERT_NEXT(a_done_free, clk, rst_n, result_valid, !busy)
    `CPO_ASSERT_NOW(a_res_busy, clk, rst_n, result_valid, busy)
    `CPO_ASSERT_NOW(a_status, clk, rst_n, result_valid, result.status != 2'd3)
    `CPO_ASSERT_NOW(a_empty, clk, rst_n, result_valid && result.overlap,
        result.status != cpo_pkg::STATUS_EMPTY)
endmodule

bind convex_polygon_overlap_sat cpo_checker u_checker (.*);
